// File: design/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the trapezoid step generator
// Field widths, register indexes, item kinds, controller state and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package stp_pkg;

    // Default values of the top-level parameters
    localparam int POSITION_BITS_DEF = 24;
    localparam int DELAY_BITS_DEF    = 16;
    localparam int RAMP_DIVIDER_DEF  = 16;
    localparam int PULSE_TICKS_DEF   = 2;

    // Fixed field widths
    localparam int KIND_W      = 2;
    localparam int INIT_W      = 16;
    localparam int CRUISE_W    = 16;
    localparam int DSTEP_W     = 12;
    localparam int MAXPOS_W    = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 3;

    // Register reset values
    localparam logic [INIT_W-1:0]   INIT_DELAY_RST   = 16'd1000;
    localparam logic [CRUISE_W-1:0] CRUISE_DELAY_RST = 16'd100;
    localparam logic [DSTEP_W-1:0]  DELAY_STEP_RST   = 12'd10;
    localparam logic [MAXPOS_W-1:0] MAX_POSITION_RST = 24'hFF_FFFF;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_DELAY      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRUISE_DELAY       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELAY_STEP         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_POSITION       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION_INVERTED = 3'd4;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CLAMP,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic tick;       // tick item (datapath gates with active)
        logic stop;       // stop item
        logic move_load;  // latch travel and direction; seed divider
        logic div_step;   // one divider iteration
        logic ramp_set;   // clamp ramp, arm the move
        logic out_imm;    // result of an item handled in its accept cycle
        logic out_move;   // result of a move start; also sets decel start
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic div_last;
    } dp_status_t;

endpackage

// File: design/stp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_ctrl: controller of the trapezoid step generator
// Handshakes, sequencing of the move start and the output valid flag.
// ----------------------------------------------------------------------------
module stp_ctrl
    import stp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [KIND_W-1:0] kind,
    output logic              out_valid,
    input  logic              out_ready,
    input  dp_status_t        status,
    output dp_cmd_t           cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;
    logic   starts_move;

    assign out_free    = !out_valid_reg || out_ready;
    assign accept      = in_valid && in_ready;
    assign starts_move = (kind == KIND_MOVE) && !status.active;
    assign out_valid   = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && starts_move)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (accept)
                begin
                    if (starts_move)
                    begin
                        cmd.move_load = 1'b1;
                    end
                    else
                    begin
                        cmd.out_imm = 1'b1;
                        cmd.tick    = (kind == KIND_TICK);
                        cmd.stop    = (kind == KIND_STOP);
                    end
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            ST_CLAMP:
            begin
                cmd.ramp_set = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.out_move = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.out_imm || cmd.out_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: design/stp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_datapath: datapath of the trapezoid step generator
// Configuration registers, move state, ramp length divider, step timing
// and the result register.
// ----------------------------------------------------------------------------
module stp_datapath
    import stp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DELAY_BITS    = DELAY_BITS_DEF,
    parameter int RAMP_DIVIDER  = RAMP_DIVIDER_DEF,
    parameter int PULSE_TICKS   = PULSE_TICKS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [POSITION_BITS-1:0] target_position,
    output logic                     step_out,
    output logic                     direction_out,
    output logic                     driver_enable,
    output logic                     busy_res,
    output logic [POSITION_BITS-1:0] position,
    output logic                     move_done
);

    localparam int P     = POSITION_BITS;
    localparam int D     = DELAY_BITS;
    localparam int CW    = (P > MAXPOS_W) ? P : MAXPOS_W;
    localparam int NUM_W = INIT_W + $clog2(RAMP_DIVIDER + 1);
    localparam int RW    = (NUM_W > P) ? NUM_W : P;
    localparam int DCW   = $clog2(NUM_W);
    localparam int EW    = ((D > DSTEP_W) ? D : DSTEP_W) + 1;
    localparam int WW    = (D > CRUISE_W) ? D : CRUISE_W;
    localparam int TB    = WW + 1;
    localparam int RCW   = (RAMP_DIVIDER > 1) ? $clog2(RAMP_DIVIDER) : 1;

    // Configuration
    logic [INIT_W-1:0]   init_delay_reg;
    logic [CRUISE_W-1:0] cruise_delay_reg;
    logic [DSTEP_W-1:0]  delay_step_reg;
    logic [MAXPOS_W-1:0] max_position_reg;
    logic                dir_inv_reg;

    // Move state
    logic [P-1:0]   cur_pos_reg, cur_pos_next;
    logic [P-1:0]   total_reg, total_next;
    logic [P-1:0]   done_cnt_reg, done_cnt_next;
    logic [P-1:0]   ramp_reg, ramp_next;
    logic [P-1:0]   decel_reg, decel_next;
    logic [D-1:0]   delay_reg, delay_next;
    logic [TB-1:0]  tick_reg, tick_next;
    logic [RCW-1:0] ramp_cnt_reg, ramp_cnt_next;
    logic           away_reg, away_next;
    logic           active_reg, active_next;

    // Divider
    logic [DSTEP_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [DCW-1:0]     div_cnt_reg, div_cnt_next;
    logic [DSTEP_W:0]   div_trial;
    logic [DSTEP_W:0]   div_diff;
    logic               div_ge;

    // Move start
    logic [CW-1:0]       tgt_ext, max_ext, tgt_clamp;
    logic [P-1:0]        tgt;
    logic                tgt_away;
    logic [INIT_W-1:0]   delay_span;
    logic [P-1:0]        half;
    logic [RW-1:0]       ramp_cand;
    logic [RW-1:0]       half_ext;

    // Tick
    logic          tick_en;
    logic          ph_accel, ph_cruise;
    logic          adjust;
    logic [EW-1:0] sd_ext, ds_ext, sd_sum, sd_dif, dly_max;
    logic [D-1:0]  sd_sub, sd_add, sd_new;
    logic [TB-1:0] wait_ticks, tick_inc, tick_limit;
    logic          pulse;
    logic          step_end;
    logic [P-1:0]  done_inc;

    // Result
    logic         step_out_reg;
    logic         dir_out_reg;
    logic         active_out_reg;
    logic [P-1:0] pos_out_reg;
    logic         done_out_reg;

    assign status.active   = active_reg;
    assign status.div_last = (div_cnt_reg == DCW'(NUM_W - 1));

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_delay_reg   <= INIT_DELAY_RST;
            cruise_delay_reg <= CRUISE_DELAY_RST;
            delay_step_reg   <= DELAY_STEP_RST;
            max_position_reg <= MAX_POSITION_RST;
            dir_inv_reg      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INITIAL_DELAY:      init_delay_reg   <= cfg_wdata[INIT_W-1:0];
                CFG_CRUISE_DELAY:       cruise_delay_reg <= cfg_wdata[CRUISE_W-1:0];
                CFG_DELAY_STEP:         delay_step_reg   <= cfg_wdata[DSTEP_W-1:0];
                CFG_MAX_POSITION:       max_position_reg <= cfg_wdata[MAXPOS_W-1:0];
                CFG_DIRECTION_INVERTED: dir_inv_reg      <= cfg_wdata[0];
                default:                ;
            endcase
        end
    end

    // Move start arithmetic
    assign tgt_ext    = CW'(target_position);
    assign max_ext    = CW'(max_position_reg);
    assign tgt_clamp  = (tgt_ext > max_ext) ? max_ext : tgt_ext;
    assign tgt        = tgt_clamp[P-1:0];
    assign tgt_away   = tgt > cur_pos_reg;
    assign delay_span = init_delay_reg - cruise_delay_reg;
    assign half       = total_reg >> 1;
    assign half_ext   = RW'(half);

    always_comb
    begin
        priority if (init_delay_reg <= cruise_delay_reg)
        begin
            ramp_cand = '0;
        end
        else if (delay_step_reg == '0)
        begin
            ramp_cand = half_ext;
        end
        else
        begin
            ramp_cand = RW'(quo_reg);
        end
    end

    // Restoring divider, one quotient bit per cycle
    assign div_trial = {rem_reg, quo_reg[NUM_W-1]};
    assign div_diff  = div_trial - {1'b0, delay_step_reg};
    assign div_ge    = div_trial >= {1'b0, delay_step_reg};

    // Step timing
    assign tick_en   = cmd.tick && active_reg;
    assign ph_accel  = done_cnt_reg < ramp_reg;
    assign ph_cruise = !ph_accel && (done_cnt_reg < decel_reg);
    assign adjust    = (tick_reg == '0) && !ph_cruise && (ramp_cnt_reg == '0);

    assign sd_ext  = EW'(delay_reg);
    assign ds_ext  = EW'(delay_step_reg);
    assign dly_max = {{(EW-D){1'b0}}, {D{1'b1}}};
    assign sd_sum  = sd_ext + ds_ext;
    assign sd_dif  = sd_ext - ds_ext;
    assign sd_sub  = (sd_ext > ds_ext) ? sd_dif[D-1:0] : '0;
    assign sd_add  = (sd_sum > dly_max) ? dly_max[D-1:0] : sd_sum[D-1:0];
    assign sd_new  = adjust ? (ph_accel ? sd_sub : sd_add) : delay_reg;

    assign wait_ticks = ph_cruise ? TB'(cruise_delay_reg) : TB'(sd_new);
    assign tick_inc   = tick_reg + TB'(1);
    assign tick_limit = wait_ticks + TB'(PULSE_TICKS);
    assign pulse      = tick_reg < TB'(PULSE_TICKS);
    assign step_end   = tick_inc >= tick_limit;
    assign done_inc   = done_cnt_reg + P'(1);

    always_comb
    begin
        cur_pos_next  = cur_pos_reg;
        total_next    = total_reg;
        done_cnt_next = done_cnt_reg;
        ramp_next     = ramp_reg;
        decel_next    = decel_reg;
        delay_next    = delay_reg;
        tick_next     = tick_reg;
        ramp_cnt_next = ramp_cnt_reg;
        away_next     = away_reg;
        active_next   = active_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        div_cnt_next  = div_cnt_reg;

        if (tick_en)
        begin
            delay_next = sd_new;
            if (step_end)
            begin
                tick_next     = '0;
                cur_pos_next  = away_reg ? cur_pos_reg + P'(1) : cur_pos_reg - P'(1);
                done_cnt_next = done_inc;
                ramp_cnt_next = (ramp_cnt_reg == RCW'(RAMP_DIVIDER - 1)) ?
                                '0 : ramp_cnt_reg + RCW'(1);
                if (done_inc >= total_reg)
                begin
                    active_next = 1'b0;
                end
            end
            else
            begin
                tick_next = tick_inc;
            end
        end

        if (cmd.stop)
        begin
            active_next = 1'b0;
            tick_next   = '0;
        end

        if (cmd.move_load)
        begin
            away_next    = tgt_away;
            total_next   = tgt_away ? tgt - cur_pos_reg : cur_pos_reg - tgt;
            rem_next     = '0;
            quo_next     = NUM_W'(delay_span) * NUM_W'(RAMP_DIVIDER);
            div_cnt_next = '0;
        end

        if (cmd.div_step)
        begin
            rem_next     = div_ge ? div_diff[DSTEP_W-1:0] : div_trial[DSTEP_W-1:0];
            quo_next     = {quo_reg[NUM_W-2:0], div_ge};
            div_cnt_next = div_cnt_reg + DCW'(1);
        end

        if (cmd.ramp_set)
        begin
            ramp_next     = (ramp_cand > half_ext) ? half : ramp_cand[P-1:0];
            done_cnt_next = '0;
            tick_next     = '0;
            delay_next    = D'(init_delay_reg);
            ramp_cnt_next = '0;
            active_next   = (total_reg != '0);
        end

        if (cmd.out_move)
        begin
            decel_next = total_reg - ramp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pos_reg  <= '0;
            total_reg    <= '0;
            done_cnt_reg <= '0;
            ramp_reg     <= '0;
            decel_reg    <= '0;
            delay_reg    <= '0;
            tick_reg     <= '0;
            ramp_cnt_reg <= '0;
            away_reg     <= 1'b0;
            active_reg   <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            cur_pos_reg  <= cur_pos_next;
            total_reg    <= total_next;
            done_cnt_reg <= done_cnt_next;
            ramp_reg     <= ramp_next;
            decel_reg    <= decel_next;
            delay_reg    <= delay_next;
            tick_reg     <= tick_next;
            ramp_cnt_reg <= ramp_cnt_next;
            away_reg     <= away_next;
            active_reg   <= active_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // Result register, holds until taken
    always_ff @(posedge clk)
    begin
        if (cmd.out_imm || cmd.out_move)
        begin
            step_out_reg   <= tick_en && pulse;
            dir_out_reg    <= away_next ^ dir_inv_reg;
            active_out_reg <= active_next;
            pos_out_reg    <= cur_pos_next;
            done_out_reg   <= cmd.out_move ? !active_reg
                                           : (tick_en && !active_next);
        end
    end

    assign step_out      = step_out_reg;
    assign direction_out = dir_out_reg;
    assign driver_enable = active_out_reg;
    assign busy_res      = active_out_reg;
    assign position      = pos_out_reg;
    assign move_done     = done_out_reg;

endmodule

// File: design/stepper_trapezoid_profile_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_profile_core: trapezoidal stepper pulse generator
// Turns tick, move and stop items into step, direction and enable levels
// with an accelerate, cruise and decelerate delay profile.
// ----------------------------------------------------------------------------
// Each input item yields exactly one result item. Tick items, stop items,
// moves that are ignored because a move is running, and unknown kinds are
// handled in their accept cycle, so ticks stream at one item per clock while
// the result side keeps up; the result register lets the next item in while
// the previous result is being taken. A move command that starts a move
// holds off the next item until the ramp length is known and the move is
// loaded: the ramp length comes from a restoring divider that resolves one
// quotient bit per cycle, followed by a clamp state and a load state.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
// ----------------------------------------------------------------------------
module stepper_trapezoid_profile_core
    import stp_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int DELAY_BITS    = DELAY_BITS_DEF,
    parameter int RAMP_DIVIDER  = RAMP_DIVIDER_DEF,
    parameter int PULSE_TICKS   = PULSE_TICKS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic [POSITION_BITS-1:0] target_position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     step_out,
    output logic                     direction_out,
    output logic                     driver_enable,
    output logic                     busy_res,
    output logic [POSITION_BITS-1:0] position,
    output logic                     move_done
);

    dp_cmd_t    cmd;
    dp_status_t status;

    stp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    stp_datapath #(
        .POSITION_BITS (POSITION_BITS),
        .DELAY_BITS    (DELAY_BITS),
        .RAMP_DIVIDER  (RAMP_DIVIDER),
        .PULSE_TICKS   (PULSE_TICKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .target_position (target_position),
        .step_out        (step_out),
        .direction_out   (direction_out),
        .driver_enable   (driver_enable),
        .busy_res        (busy_res),
        .position        (position),
        .move_done       (move_done)
    );

    // A pending result is never overwritten
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(cmd.out_imm || cmd.out_move)
    ) else $error("result register overwritten while held");

    // No input is taken while the divider runs
    a_div_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !in_ready
    ) else $error("input accepted during ramp division");

    // A finished move is no longer busy
    a_done_not_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && move_done) |-> !busy_res
    ) else $error("move_done reported while still busy");

    // Starting a move hands the divider a fresh run
    a_move_then_divide: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.move_load |=> cmd.div_step
    ) else $error("move start not followed by division");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the trapezoid step generator
// Drives tick, move and stop items through the input handshake and keeps
// its own motion model: position, travel, ramp and per-step delay. It checks
// every result item against that model, field by field. Directed tests cover
// the corner cases and register extremes. Random traffic follows, under
// several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import stp_pkg::*;

    localparam int          POS_W        = POSITION_BITS_DEF;
    localparam int          RAMP_DIV     = RAMP_DIVIDER_DEF;
    localparam int          PULSE_LEN    = PULSE_TICKS_DEF;
    localparam int unsigned DELAY_MAX    = (1 << DELAY_BITS_DEF) - 1;
    localparam int          SETTLE_CYC   = 32;
    localparam int          HOLD_CYCLES  = 150;
    localparam longint      CYCLE_LIMIT  = 400000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef enum logic [1:0] {PH_ACCEL, PH_CRUISE, PH_DECEL} ramp_phase_t;

    typedef struct packed {
        logic             step;
        logic             dir;
        logic             enable;
        logic             busy;
        logic [POS_W-1:0] pos;
        logic             done;
    } motor_status_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [KIND_W-1:0]      kind = KIND_TICK;
    logic [POS_W-1:0]       target_position = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   step_out;
    logic                   direction_out;
    logic                   driver_enable;
    logic                   busy_res;
    logic [POS_W-1:0]       position;
    logic                   move_done;

    // motion model: registers
    logic [15:0]      cfg_init   = INIT_DELAY_RST;
    logic [15:0]      cfg_cruise = CRUISE_DELAY_RST;
    logic [11:0]      cfg_dstep  = DELAY_STEP_RST;
    logic [POS_W-1:0] cfg_maxpos = MAX_POSITION_RST;
    logic             cfg_dinv   = 1'b0;
    // motion model: state
    logic [POS_W-1:0] axis_pos     = '0;
    int unsigned      travel_steps = 0;
    int unsigned      steps_taken  = 0;
    int unsigned      ramp_steps   = 0;
    int unsigned      cur_delay    = 0;
    int unsigned      tick_in_step = 0;
    logic             heading_out  = 1'b0;
    logic             moving       = 1'b0;

    motor_status_t expected_status_q[$];
    motor_status_t want_status;

    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;
    int     hold_requests  = 0;
    int     hold_served    = 0;
    int     hold_left      = 0;
    int     mismatches     = 0;
    longint cycle_cnt      = 0;

    stepper_trapezoid_profile_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .target_position (target_position),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .step_out        (step_out),
        .direction_out   (direction_out),
        .driver_enable   (driver_enable),
        .busy_res        (busy_res),
        .position        (position),
        .move_done       (move_done)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Advances the motion model by one accepted item, returns the status it shows.
    function automatic motor_status_t next_motor_status(input logic [KIND_W-1:0] k,
                                                        input logic [POS_W-1:0] tgt);
        motor_status_t     r;
        logic              pulse;
        logic              done;
        logic [POS_W-1:0]  dest;
        longint unsigned   ramp;
        ramp_phase_t       ph;
        int unsigned       wait_len;
        pulse = 1'b0;
        done  = 1'b0;
        case (k)
            KIND_TICK:
            begin
                if (moving)
                begin
                    if (steps_taken < ramp_steps)
                        ph = PH_ACCEL;
                    else if (steps_taken < travel_steps - ramp_steps)
                        ph = PH_CRUISE;
                    else
                        ph = PH_DECEL;
                    // delay moves once per ramp divider, on the first tick of the step
                    if (tick_in_step == 0 && ph != PH_CRUISE && steps_taken % RAMP_DIV == 0)
                    begin
                        if (ph == PH_ACCEL)
                            cur_delay = (cur_delay > cfg_dstep) ? cur_delay - cfg_dstep : 0;
                        else if (cur_delay + cfg_dstep > DELAY_MAX)
                            cur_delay = DELAY_MAX;
                        else
                            cur_delay = cur_delay + cfg_dstep;
                    end
                    wait_len = (ph == PH_CRUISE) ? 32'(cfg_cruise) : cur_delay;
                    pulse = tick_in_step < PULSE_LEN;
                    tick_in_step++;
                    if (tick_in_step >= PULSE_LEN + wait_len)
                    begin
                        tick_in_step = 0;
                        axis_pos = heading_out ? axis_pos + POS_W'(1) : axis_pos - POS_W'(1);
                        steps_taken++;
                        if (steps_taken >= travel_steps)
                            moving = 1'b0;
                    end
                    done = !moving;
                end
            end
            KIND_MOVE:
            begin
                if (!moving)
                begin
                    dest = (tgt > cfg_maxpos) ? cfg_maxpos : tgt;
                    heading_out  = dest > axis_pos;
                    travel_steps = heading_out ? 32'(dest - axis_pos) : 32'(axis_pos - dest);
                    if (cfg_init <= cfg_cruise)
                        ramp = 0;
                    else if (cfg_dstep == 0)
                        ramp = 64'(travel_steps / 2);
                    else
                        ramp = (longint'(cfg_init - cfg_cruise) * RAMP_DIV) / cfg_dstep;
                    if (ramp > travel_steps / 2)
                        ramp = 64'(travel_steps / 2);
                    ramp_steps   = 32'(ramp);
                    steps_taken  = 0;
                    tick_in_step = 0;
                    cur_delay    = 32'(cfg_init);
                    moving       = travel_steps != 0;
                    done         = !moving;
                end
            end
            KIND_STOP:
            begin
                moving       = 1'b0;
                tick_in_step = 0;
            end
            default: ;
        endcase
        r.step   = pulse;
        r.dir    = heading_out ^ cfg_dinv;
        r.enable = moving;
        r.busy   = moving;
        r.pos    = axis_pos;
        r.done   = done;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_status_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: result item with nothing expected, position %0d",
                         $time, position);
            end
            else
            begin
                want_status = expected_status_q.pop_front();
                check_field("step_out", 32'(want_status.step), 32'(step_out));
                check_field("direction_out", 32'(want_status.dir), 32'(direction_out));
                check_field("driver_enable", 32'(want_status.enable), 32'(driver_enable));
                check_field("busy_res", 32'(want_status.busy), 32'(busy_res));
                check_field("position", 32'(want_status.pos), 32'(position));
                check_field("move_done", 32'(want_status.done), 32'(move_done));
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            out_ready   <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic send_item(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] tgt);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid        <= 1'b1;
        kind            <= k;
        target_position <= tgt;
        do
            @(posedge clk);
        while (!in_ready);
        expected_status_q.push_back(next_motor_status(k, tgt));
        @(negedge clk);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(KIND_TICK, POS_W'($urandom));
    endtask

    task automatic finish_move();
        while (moving)
            send_item(KIND_TICK, POS_W'($urandom));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    task automatic apply_profile(input logic [15:0] init_d, input logic [15:0] cruise_d,
                                 input logic [11:0] dstep, input logic [POS_W-1:0] maxpos,
                                 input logic dinv);
        if (moving)
            send_item(KIND_STOP, POS_W'($urandom));
        wait_drained();
        write_reg(CFG_INITIAL_DELAY, CFG_DATA_W'(init_d));
        write_reg(CFG_CRUISE_DELAY, CFG_DATA_W'(cruise_d));
        write_reg(CFG_DELAY_STEP, CFG_DATA_W'(dstep));
        write_reg(CFG_MAX_POSITION, CFG_DATA_W'(maxpos));
        write_reg(CFG_DIRECTION_INVERTED, CFG_DATA_W'(dinv));
        cfg_we <= 1'b0;
        @(negedge clk);
        cfg_init   = init_d;
        cfg_cruise = cruise_d;
        cfg_dstep  = dstep;
        cfg_maxpos = maxpos;
        cfg_dinv   = dinv;
    endtask

    task automatic random_profile();
        int r;
        logic [11:0] dstep;
        r = $urandom_range(99);
        dstep = (r < 85) ? 12'($urandom_range(1, 5)) : 12'($urandom_range(6, 4095));
        apply_profile(16'($urandom_range(1, 9)), 16'($urandom_range(1, 4)), dstep,
                      ($urandom_range(9) == 0) ? POS_W'(0) : POS_W'($urandom_range(4, 40)),
                      1'($urandom_range(1)));
    endtask

    // ---- directed tests ----

    task automatic test_idle_items();
        send_item(KIND_TICK, 24'hFFFFFF);
        send_item(KIND_UNUSED, 24'h000000);
        send_item(KIND_STOP, 24'hA5A5A5);
        send_item(KIND_MOVE, 24'h000000);     // zero travel, done at once
    endtask

    task automatic test_full_move();
        apply_profile(16'd4, 16'd1, 12'd3, 24'd20, 1'b0);
        send_item(KIND_MOVE, 24'hFFFFFF);     // clamped to max position
        send_ticks(10);
        send_item(KIND_MOVE, 24'h000003);     // busy, ignored
        finish_move();
    endtask

    task automatic test_stop_and_direction();
        apply_profile(16'd3, 16'd1, 12'd2, 24'd20, 1'b1);
        send_item(KIND_MOVE, 24'd3);          // toward home
        send_ticks(9);
        send_item(KIND_STOP, 24'd0);
        send_item(KIND_TICK, 24'd0);
        send_item(KIND_MOVE, 24'd12);
        finish_move();
    endtask

    task automatic test_ramp_corners();
        apply_profile(16'd2, 16'd3, 12'd1, 24'd40, 1'b0);   // initial not above cruise
        send_item(KIND_MOVE, 24'd20);
        finish_move();
        apply_profile(16'd5, 16'd1, 12'd60, 24'd40, 1'b0);  // delay saturates at zero
        send_item(KIND_MOVE, 24'd38);
        finish_move();
        apply_profile(16'd6, 16'd2, 12'd0, 24'd40, 1'b1);   // zero delay step
        send_item(KIND_MOVE, 24'd32);
        finish_move();
        apply_profile(16'd3, 16'd1, 12'd1, 24'd0, 1'b0);    // max position zero
        send_item(KIND_MOVE, 24'hFFFFFF);
        finish_move();
        send_item(KIND_MOVE, 24'h5A5A5A);
    endtask

    task automatic test_register_extremes();
        apply_profile(16'hFFFF, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 1'b1);
        send_item(KIND_MOVE, 24'hFFFFFF);
        send_ticks(5);
        send_item(KIND_STOP, 24'd0);
        apply_profile(16'hFFFF, 16'h0001, 12'hFFF, 24'hFFFFFF, 1'b0);
        send_item(KIND_MOVE, 24'h800000);
        send_ticks(4);
        apply_profile(16'hFFFF, 16'h0001, 12'h001, 24'h7FFFFF, 1'b0);
        send_item(KIND_MOVE, 24'hFFFFFF);
        send_ticks(3);
        send_item(KIND_STOP, 24'd0);
    endtask

    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_profile(16'd3, 16'd1, 12'd2, 24'd30, 1'b0);
        send_item(KIND_MOVE, 24'd25);
        hold_requests = hold_requests + 1;
        send_ticks(60);
        finish_move();
    endtask

    // ---- random traffic ----

    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int          sent;
        int          moves_left;
        int          r;
        logic [POS_W-1:0] tgt;
        sent           = 0;
        moves_left     = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (moving)
            begin
                if (r < 93)
                begin
                    send_item(KIND_TICK, POS_W'($urandom));
                    sent++;
                end
                else if (r < 96)
                    send_item(KIND_MOVE, POS_W'($urandom));
                else if (r < 98)
                begin
                    send_item(KIND_STOP, POS_W'($urandom));
                    sent++;
                end
                else
                    send_item(KIND_UNUSED, POS_W'($urandom));
            end
            else if (moves_left == 0)
            begin
                random_profile();
                moves_left = $urandom_range(2, 4);
            end
            else if (r < 85)
            begin
                tgt = (r < 40) ? POS_W'($urandom) : POS_W'($urandom_range(0, cfg_maxpos + 4));
                send_item(KIND_MOVE, tgt);
                moves_left--;
                sent++;
            end
            else if (r < 90)
            begin
                send_item(KIND_TICK, POS_W'($urandom));
                sent++;
            end
            else if (r < 95)
            begin
                send_item(KIND_STOP, POS_W'($urandom));
                sent++;
            end
            else
                send_item(KIND_UNUSED, POS_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_items();
        test_full_move();
        test_stop_and_direction();
        test_ramp_corners();
        test_register_extremes();
        test_output_backpressure();
        test_random_traffic(225, 0, 0);
        test_random_traffic(225, 54, 0);
        test_random_traffic(225, 0, 54);
        test_random_traffic(225, 36, 36);

        wait_drained();
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
